// ===== design/arosc_pkg.sv =====
// Shared types, constants and helpers for the AR order selection criteria block.
package arosc_pkg;

	localparam int ORDER_W = 7;
	localparam logic [ORDER_W-1:0] MAX_ORDER = 7'd64;
	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic signed [41:0] TERM_BIG = 42'sh100_0000_0000;
	localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
	localparam logic signed [49:0] SAT_LO = -50'sd2147483648;

	// configuration register indexes
	localparam logic [1:0] REG_SAMPLE_COUNT = 2'd0;
	localparam logic [1:0] REG_LOG_N = 2'd1;
	localparam logic [1:0] REG_LOG_LOG_N = 2'd2;

	typedef struct packed {
		logic start;
		logic [63:0] dividend;
		logic [47:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [63:0] quotient;
	} div_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		logic signed [31:0] r;
		if (v > SAT_HI) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < SAT_LO) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== design/arosc_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module arosc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  arosc_pkg::div_req_t req,
	output arosc_pkg::div_rsp_t rsp
);
	import arosc_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] dvd_q;
	logic [47:0] rem_q;
	logic [47:0] dsr_q;
	logic [48:0] rs;
	logic [48:0] diff;
	logic        ge;

	assign rs   = {rem_q, dvd_q[63]};
	assign ge   = rs >= {1'b0, dsr_q};
	assign diff = rs - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= 48'd0;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits 48 bits
			rem_q <= ge ? diff[47:0] : rs[47:0];
			dvd_q <= {dvd_q[62:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

// ===== design/arosc_log.sv =====
// Serial natural log: one-bit normalize shifts, 16 squaring steps, scale by ln 2.
module arosc_log (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [31:0]        x,
	output logic               busy,
	output logic signed [31:0] result
);
	import arosc_pkg::*;

	localparam logic [1:0] PH_NORM = 2'd0;
	localparam logic [1:0] PH_SQ   = 2'd1;
	localparam logic [1:0] PH_FIN  = 2'd2;

	logic               busy_q;
	logic [1:0]         ph_q;
	logic [31:0]        xn_q;
	logic [4:0]         s_q;
	logic [30:0]        m_q;
	logic [15:0]        frac_q;
	logic [3:0]         cnt_q;
	logic signed [31:0] res_q;
	logic [61:0]        sq;
	logic [31:0]        sq_top;
	logic signed [21:0] l2;
	logic signed [52:0] prod;
	logic signed [52:0] rnd;

	assign sq     = 62'(m_q) * 62'(m_q);
	assign sq_top = sq[61:30];
	assign l2     = ((22'sd15 - $signed({17'b0, s_q})) <<< 16) + $signed({6'b0, frac_q});
	assign prod   = 53'(l2) * $signed({23'b0, LN2_Q30});
	assign rnd    = (prod + 53'sd536870912) >>> 30;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= PH_NORM;
		end else begin
			if (start) begin
				busy_q <= (x != 32'd0);
				ph_q   <= PH_NORM;
			end else if (busy_q) begin
				case (ph_q)
					PH_NORM: begin
						if (xn_q[31]) ph_q <= PH_SQ;
					end
					PH_SQ: begin
						if (cnt_q == 4'd15) ph_q <= PH_FIN;
					end
					PH_FIN: begin
						busy_q <= 1'b0;
					end
					default: begin
						busy_q <= 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			xn_q <= x;
			s_q  <= 5'd0;
			if (x == 32'd0) res_q <= 32'sh8000_0000;
		end else if (busy_q) begin
			case (ph_q)
				PH_NORM: begin
					if (xn_q[31]) begin
						// mantissa in Q1.30
						m_q    <= xn_q[31:1];
						frac_q <= 16'd0;
						cnt_q  <= 4'd0;
					end else begin
						xn_q <= {xn_q[30:0], 1'b0};
						s_q  <= s_q + 5'd1;
					end
				end
				PH_SQ: begin
					frac_q <= {frac_q[14:0], sq_top[31]};
					m_q    <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
					cnt_q  <= cnt_q + 4'd1;
				end
				PH_FIN: begin
					res_q <= rnd[31:0];
				end
				default: begin
					res_q <= res_q;
				end
			endcase
		end
	end

	assign busy   = busy_q;
	assign result = res_q;

endmodule

// ===== design/ar_order_selection_criteria_core.sv =====
// AR model order selection criteria: top level with sequencer and result registers.
//
// Input channel (in_valid/in_stall): an item with is_first set loads the order-zero
// error power and restarts the order count; it gives no result.
// Each other item carries the reflection coefficient of the next order k and gives
// one result (two for order 1: order 0 with last low, then order 1 with last high).
// Reflections past order 64 are dropped without a result.
// Per reflection item, up to eight quotients run one after another on the bit-serial
// divider; a quotient that is a special case does not use the divider. The log unit
// runs beside the divider from the first quotient, and the result waits for the log
// unit when it has not finished.
// One item is in work at a time: in_stall stays high from the transfer of a
// reflection until its last result has been taken.
// Output channel (out_valid/out_stall): results are held in registers and stay put
// while out_stall is high. Configuration writes (cfg_write) are taken in any cycle.
// Reset clears the order count, error power, CAT sum and sets the FSIC product to one.
module ar_order_selection_criteria_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               is_first,
	input  logic [31:0]        error_power,
	input  logic signed [15:0] reflection,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [6:0]         order,
	output logic [31:0]        residual_power,
	output logic [31:0]        fpe,
	output logic signed [31:0] mdl,
	output logic signed [31:0] aic,
	output logic signed [31:0] cat,
	output logic signed [31:0] hq,
	output logic signed [31:0] aicc,
	output logic signed [31:0] fsic,
	output logic signed [31:0] cic,
	output logic               last
);
	import arosc_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_FAC   = 4'd1;
	localparam logic [3:0] S_EPS   = 4'd2;
	localparam logic [3:0] S_LOG   = 4'd3;
	localparam logic [3:0] S_SETUP = 4'd4;
	localparam logic [3:0] S_WAIT  = 4'd5;
	localparam logic [3:0] S_FINAL = 4'd6;
	localparam logic [3:0] S_OUT0  = 4'd7;
	localparam logic [3:0] S_OUT1  = 4'd8;

	localparam logic [2:0] JOB_FPE  = 3'd0;
	localparam logic [2:0] JOB_MDL  = 3'd1;
	localparam logic [2:0] JOB_AIC  = 3'd2;
	localparam logic [2:0] JOB_HQ   = 3'd3;
	localparam logic [2:0] JOB_AICC = 3'd4;
	localparam logic [2:0] JOB_CAT  = 3'd5;
	localparam logic [2:0] JOB_A    = 3'd6;
	localparam logic [2:0] JOB_FSIC = 3'd7;

	// configuration
	logic [15:0]        n_q;
	logic [20:0]        logn_q;
	logic signed [31:0] lln_q;

	// running state
	logic [31:0] prev_q;
	logic [47:0] catsum_q;
	logic [31:0] fsicp_q;
	logic [6:0]  order_q;

	logic [3:0]  state_q;
	logic [2:0]  job_q;

	// per-item work registers
	logic [6:0]         k_q;
	logic signed [15:0] r_q;
	logic [30:0]        fac_q;
	logic [31:0]        eps_q;
	logic [31:0]        old_q;
	logic signed [41:0] mdl_t_q, aic_t_q, hq_t_q, aicc_t_q;
	logic [47:0]        tk_q;
	logic [47:0]        a_q;
	logic [31:0]        fsicn_q;

	// result registers
	logic [31:0]        fpe_q;
	logic signed [31:0] mdl_q, aic_q, cat_q, hq_q, aicc_q, fsic_q, cic_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	logic               log_busy;
	logic signed [31:0] log_res;

	logic signed [31:0] r2;
	logic [62:0]        ep;
	logic [15:0]        k16;
	logic               ok1, ok2, ok3, n_zero;
	logic [31:0]        lln_abs;
	logic [31:0]        ma;
	logic [16:0]        mb;
	logic [48:0]        prod;
	logic               skip;
	logic [63:0]        q;
	logic               in_xfer;
	logic signed [49:0] ln_x;
	logic signed [49:0] fs_sum;
	logic [48:0]        cs_sum;

	assign in_xfer = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	assign r2      = r_q * r_q;
	assign ep      = 63'(prev_q) * 63'(fac_q);
	assign k16     = {9'b0, k_q};
	assign n_zero  = (n_q == 16'd0);
	assign ok1     = n_q > (k16 + 16'd1);
	assign ok2     = n_q > (k16 + 16'd2);
	assign ok3     = n_q > k16;
	assign lln_abs = lln_q[31] ? (32'd0 - lln_q) : lln_q;
	assign prod    = 49'(ma) * 49'(mb);
	assign q       = div_rsp.quotient;

	// operand select and special-case detection for the current quotient
	always_comb begin
		ma                = eps_q;
		mb                = 17'd0;
		skip              = 1'b0;
		div_req.dividend  = 64'(prod);
		div_req.divisor   = {32'b0, n_q};
		case (job_q)
			JOB_FPE: begin
				mb              = 17'(n_q) + 17'(k_q) + 17'd1;
				div_req.divisor = {32'b0, n_q - k16 - 16'd1};
				skip            = !ok1;
			end
			JOB_MDL: begin
				ma   = {11'b0, logn_q};
				mb   = 17'(k_q);
				skip = n_zero;
			end
			JOB_AIC: begin
				ma   = ONE_Q16;
				mb   = {9'b0, k_q, 1'b0};
				skip = n_zero;
			end
			JOB_HQ: begin
				ma   = lln_abs;
				mb   = {9'b0, k_q, 1'b0};
				skip = n_zero;
			end
			JOB_AICC: begin
				ma              = ONE_Q16;
				mb              = {9'b0, k_q, 1'b0} + 17'd2;
				div_req.divisor = {32'b0, n_q - k16 - 16'd2};
				skip            = !ok2;
			end
			JOB_CAT: begin
				// divisor is N * eps, numerator (N - k) scaled by 2^32
				ma               = eps_q;
				mb               = 17'(n_q);
				div_req.dividend = {16'b0, n_q - k16, 32'b0};
				div_req.divisor  = prod[47:0];
				skip             = !ok3 || (eps_q == 32'd0);
			end
			JOB_A: begin
				div_req.dividend = {16'b0, catsum_q};
				skip             = n_zero;
			end
			JOB_FSIC: begin
				ma              = fsicp_q;
				mb              = 17'(n_q) + 17'd2 - 17'(k_q);
				div_req.divisor = {32'b0, n_q - k16};
				skip            = !ok3;
			end
			default: begin
				skip = 1'b1;
			end
		endcase
		div_req.start = (state_q == S_SETUP) && !skip;
	end

	arosc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	arosc_log u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_LOG),
		.x      (eps_q),
		.busy   (log_busy),
		.result (log_res)
	);

	assign ln_x   = 50'(log_res);
	assign fs_sum = ln_x + $signed({18'b0, fsicp_q}) - $signed({18'b0, ONE_Q16});
	assign cs_sum = {1'b0, catsum_q} + {1'b0, tk_q};

	// control state and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			job_q    <= JOB_FPE;
			n_q      <= 16'd1024;
			logn_q   <= 21'd454277;
			lln_q    <= 32'sd126992;
			prev_q   <= 32'd0;
			catsum_q <= 48'd0;
			fsicp_q  <= ONE_Q16;
			order_q  <= 7'd0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_SAMPLE_COUNT: n_q    <= cfg_data[15:0];
					REG_LOG_N:        logn_q <= cfg_data[20:0];
					REG_LOG_LOG_N:    lln_q  <= cfg_data;
					default:          n_q    <= n_q;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (is_first) begin
							prev_q   <= error_power;
							catsum_q <= 48'd0;
							fsicp_q  <= ONE_Q16;
							order_q  <= 7'd0;
						end else if (order_q < MAX_ORDER) begin
							state_q <= S_FAC;
						end
					end
				end
				S_FAC: state_q <= S_EPS;
				S_EPS: state_q <= S_LOG;
				S_LOG: begin
					job_q   <= JOB_FPE;
					state_q <= S_SETUP;
				end
				S_SETUP: begin
					if (!skip) begin
						state_q <= S_WAIT;
					end else if (job_q == JOB_FSIC) begin
						state_q <= S_FINAL;
					end else begin
						job_q <= job_q + 3'd1;
					end
				end
				S_WAIT: begin
					if (div_rsp.done) begin
						if (job_q == JOB_FSIC) begin
							state_q <= S_FINAL;
						end else begin
							job_q   <= job_q + 3'd1;
							state_q <= S_SETUP;
						end
					end
				end
				S_FINAL: begin
					if (!log_busy) begin
						catsum_q <= cs_sum[48] ? SUM_MAX : cs_sum[47:0];
						fsicp_q  <= fsicn_q;
						prev_q   <= eps_q;
						order_q  <= k_q;
						state_q  <= (k_q == 7'd1) ? S_OUT0 : S_OUT1;
					end
				end
				S_OUT0: begin
					if (!out_stall) state_q <= S_OUT1;
				end
				S_OUT1: begin
					if (!out_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					k_q <= order_q + 7'd1;
					r_q <= reflection;
				end
			end
			S_FAC: fac_q <= 31'(32'h4000_0000 - r2);
			S_EPS: eps_q <= ep[61:30];
			S_SETUP: begin
				if (skip) begin
					case (job_q)
						JOB_FPE:  fpe_q    <= 32'hFFFF_FFFF;
						JOB_MDL:  mdl_t_q  <= TERM_BIG;
						JOB_AIC:  aic_t_q  <= TERM_BIG;
						JOB_HQ: begin
							if (lln_q == 32'sd0) hq_t_q <= 42'sd0;
							else hq_t_q <= lln_q[31] ? -TERM_BIG : TERM_BIG;
						end
						JOB_AICC: aicc_t_q <= TERM_BIG;
						JOB_CAT:  tk_q     <= ok3 ? SUM_MAX : 48'd0;
						JOB_A:    a_q      <= (catsum_q != 48'd0) ? SUM_MAX : 48'd0;
						JOB_FSIC: fsicn_q  <= 32'hFFFF_FFFF;
						default:  fsicn_q  <= fsicn_q;
					endcase
				end
			end
			S_WAIT: begin
				if (div_rsp.done) begin
					case (job_q)
						JOB_FPE:  fpe_q    <= (q[63:32] != 32'd0) ? 32'hFFFF_FFFF : q[31:0];
						JOB_MDL:  mdl_t_q  <= $signed({1'b0, q[40:0]});
						JOB_AIC:  aic_t_q  <= $signed({1'b0, q[40:0]});
						JOB_HQ: begin
							hq_t_q <= lln_q[31] ? -$signed({1'b0, q[40:0]})
							                    : $signed({1'b0, q[40:0]});
						end
						JOB_AICC: aicc_t_q <= $signed({1'b0, q[40:0]});
						JOB_CAT:  tk_q     <= (q[63:48] != 16'd0) ? SUM_MAX : q[47:0];
						JOB_A:    a_q      <= q[47:0];
						JOB_FSIC: fsicn_q  <= (q[63:32] != 32'd0) ? 32'hFFFF_FFFF : q[31:0];
						default:  fsicn_q  <= fsicn_q;
					endcase
				end
			end
			S_FINAL: begin
				if (!log_busy) begin
					old_q  <= prev_q;
					mdl_q  <= sat32(ln_x + 50'(mdl_t_q));
					aic_q  <= sat32(ln_x + 50'(aic_t_q));
					hq_q   <= sat32(ln_x + 50'(hq_t_q));
					aicc_q <= sat32(ln_x + 50'(aicc_t_q));
					cat_q  <= sat32($signed({2'b0, a_q}) - $signed({2'b0, tk_q}));
					fsic_q <= sat32(fs_sum);
					cic_q  <= sat32(fs_sum + $signed({27'b0, k_q, 16'b0}));
				end
			end
			default: begin
				old_q <= old_q;
			end
		endcase
	end

	assign out_valid      = (state_q == S_OUT0) || (state_q == S_OUT1);
	assign last           = (state_q == S_OUT1);
	assign order          = (state_q == S_OUT0) ? 7'd0 : k_q;
	assign residual_power = (state_q == S_OUT0) ? old_q : eps_q;
	assign fpe            = fpe_q;
	assign mdl            = mdl_q;
	assign aic            = aic_q;
	assign cat            = cat_q;
	assign hq             = hq_q;
	assign aicc           = aicc_q;
	assign fsic           = fsic_q;
	assign cic            = cic_q;

endmodule

// ===== design/arosc_checker.sv =====
// Port-level checker for the AR order selection criteria block, bound to the top level.
module arosc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [6:0]  order,
	input logic [31:0] residual_power,
	input logic        last
);
	import arosc_pkg::*;

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(order) && $stable(residual_power)
		&& $stable(last))
		else $error("stalled result changed");

	// no new input transfer while a result is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

	// only the order-zero repeat is a non-final result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> order == 7'd0)
		else $error("non-final result with nonzero order");

	// order-zero result is followed directly by the order-one result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid && last && order == 7'd1)
		else $error("order one did not follow order zero");

	// orders stay within range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> order <= MAX_ORDER)
		else $error("order out of range");

endmodule

bind ar_order_selection_criteria_core arosc_checker u_arosc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.order          (order),
	.residual_power (residual_power),
	.last           (last)
);

// ===== tb/sv/arosc_criteria_check.sv =====
// Checker for the AR order selection criteria block: predicts each result and compares it.
`timescale 1ns / 1ps
module arosc_criteria_check
	import arosc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               is_first,
	input  logic [31:0]        error_power,
	input  logic signed [15:0] reflection,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [6:0]         order,
	input  logic [31:0]        residual_power,
	input  logic [31:0]        fpe,
	input  logic signed [31:0] mdl,
	input  logic signed [31:0] aic,
	input  logic signed [31:0] cat,
	input  logic signed [31:0] hq,
	input  logic signed [31:0] aicc,
	input  logic signed [31:0] fsic,
	input  logic signed [31:0] cic,
	input  logic               last,
	output int                 results_owed,
	output int                 mismatch_count
);

	typedef struct {
		logic [6:0]  ord;
		logic [31:0] power;
		logic [31:0] fpe_v;
		logic [31:0] mdl_v, aic_v, cat_v, hq_v, aicc_v, fsic_v, cic_v;
		logic        last_v;
	} criteria_t;

	localparam longint BIG_PENALTY = 64'sd1 << 40;
	localparam longint ACC_MAX = (64'sd1 << 48) - 1;
	localparam longint Q16_ONE = 64'sd65536;

	criteria_t expected_results[$];

	// copy of the block's registers and order state
	logic [15:0]        n_reg;
	logic [20:0]        logn_reg;
	logic signed [31:0] loglogn_reg;
	logic [31:0]        prev_pw;
	longint             cat_acc;
	logic [31:0]        fsic_prod;
	int                 cur_ord;

	function automatic logic [31:0] clip32(longint v);
		if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic longint nat_log(logic [31:0] x);
		int p;
		longint unsigned m;
		longint frac, l2;
		if (x == 0) return -64'sd2147483648;
		p = 31;
		while (!x[p]) p--;
		m = (p <= 30) ? (64'(x) << (30 - p)) : (64'(x) >> 1);
		frac = 0;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= 64'h8000_0000) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		l2 = longint'(p - 16) * 65536 + frac;
		return (l2 * 64'sd744261118 + (64'sd1 <<< 29)) >>> 30;
	endfunction

	task automatic predict_criteria(logic first, logic [31:0] pw, logic signed [15:0] refl);
		longint k, r, n, eps, lnv, den, num, term, q, tk, a, fs;
		logic [31:0] old;
		criteria_t c;
		if (first) begin
			prev_pw = pw;
			cat_acc = 0;
			fsic_prod = ONE_Q16;
			cur_ord = 0;
			return;
		end
		if (cur_ord >= int'(MAX_ORDER)) return;
		k = cur_ord + 1;
		r = longint'(refl);
		eps = (longint'(prev_pw) * ((64'sd1 << 30) - r * r)) >>> 30;
		n = longint'(n_reg);
		lnv = nat_log(eps[31:0]);

		den = n - k - 1;
		if (den <= 0) c.fpe_v = 32'hFFFF_FFFF;
		else begin
			q = eps * (n + k + 1) / den;
			c.fpe_v = (q > 64'sh FFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
		end
		term = (n != 0) ? (k * longint'(logn_reg)) / n : BIG_PENALTY;
		c.mdl_v = clip32(lnv + term);
		term = (n != 0) ? ((2 * k) << 16) / n : BIG_PENALTY;
		c.aic_v = clip32(lnv + term);
		num = 2 * k * longint'(loglogn_reg);
		if (n != 0) term = num / n;
		else term = (num > 0) ? BIG_PENALTY : ((num < 0) ? -BIG_PENALTY : 0);
		c.hq_v = clip32(lnv + term);
		den = n - k - 2;
		term = (den > 0) ? ((2 * (k + 1)) << 16) / den : BIG_PENALTY;
		c.aicc_v = clip32(lnv + term);

		if (k >= n) tk = 0;
		else if (n * eps == 0) tk = ACC_MAX;
		else begin
			tk = ((n - k) << 32) / (n * eps);
			if (tk > ACC_MAX) tk = ACC_MAX;
		end
		if (n != 0) a = cat_acc / n;
		else a = (cat_acc != 0) ? ACC_MAX : 0;
		c.cat_v = clip32(a - tk);

		fs = lnv + longint'(fsic_prod) - Q16_ONE;
		c.fsic_v = clip32(fs);
		c.cic_v = clip32(fs + (k << 16));

		cat_acc = cat_acc + tk;
		if (cat_acc > ACC_MAX) cat_acc = ACC_MAX;
		den = n - k;
		if (den <= 0) fsic_prod = 32'hFFFF_FFFF;
		else begin
			q = longint'(fsic_prod) * (n + 2 - k) / den;
			fsic_prod = (q > 64'sh FFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
		end
		old = prev_pw;
		prev_pw = eps[31:0];
		cur_ord = int'(k);

		// order 0 repeats the order-1 criteria with the initial power
		if (k == 1) begin
			c.ord = 7'd0;
			c.power = old;
			c.last_v = 1'b0;
			expected_results.push_back(c);
		end
		c.ord = k[6:0];
		c.power = eps[31:0];
		c.last_v = 1'b1;
		expected_results.push_back(c);
	endtask

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			mismatch_count++;
			$display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_reg <= 16'd1024;
			logn_reg <= 21'd454277;
			loglogn_reg <= 32'sd126992;
			prev_pw = '0;
			cat_acc = 0;
			fsic_prod = ONE_Q16;
			cur_ord = 0;
			expected_results.delete();
			mismatch_count = 0;
			results_owed = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_SAMPLE_COUNT: n_reg <= cfg_data[15:0];
					REG_LOG_N: logn_reg <= cfg_data[20:0];
					REG_LOG_LOG_N: loglogn_reg <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_criteria(is_first, error_power, reflection);
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected transfer, order %0d actual", $time, order);
				end else begin
					criteria_t e;
					e = expected_results.pop_front();
					check_field("order", 32'(e.ord), 32'(order));
					check_field("residual_power", e.power, residual_power);
					check_field("fpe", e.fpe_v, fpe);
					check_field("mdl", e.mdl_v, mdl);
					check_field("aic", e.aic_v, aic);
					check_field("cat", e.cat_v, cat);
					check_field("hq", e.hq_v, hq);
					check_field("aicc", e.aicc_v, aicc);
					check_field("fsic", e.fsic_v, fsic);
					check_field("cic", e.cic_v, cic);
					check_field("last", 32'(e.last_v), 32'(last));
				end
			end
			results_owed = expected_results.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the AR order selection criteria block: stimulus and verdict.
`timescale 1ns / 1ps
module tb;
	import arosc_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               cfg_write;
	logic [1:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic               is_first;
	logic [31:0]        error_power;
	logic signed [15:0] reflection;
	logic               out_valid;
	logic               out_stall;
	logic [6:0]         order;
	logic [31:0]        residual_power, fpe;
	logic signed [31:0] mdl, aic, cat, hq, aicc, fsic, cic;
	logic               last;
	int                 results_owed;
	int                 mismatch_count;
	int                 items_sent;

	ar_order_selection_criteria_core u_top (.*);

	arosc_criteria_check u_check (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("ar_order_selection_criteria_core: mismatch");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver: random stalls, one long hold so the block backs up its input
	initial begin
		int g, open_len, cyc;
		bit held;
		out_stall = 1'b0;
		cyc = 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && cyc >= 20000) begin
				out_stall <= 1'b1;
				repeat (3000) @(posedge clk);
				held = 1;
			end
			g = pick_gap();
			if (g > 0) begin
				out_stall <= 1'b1;
				repeat (g) @(posedge clk);
				cyc += g;
			end
			out_stall <= 1'b0;
			open_len = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 8);
			repeat (open_len) @(posedge clk);
			cyc += open_len + 1;
		end
	end

	task automatic send_item(logic first, logic [31:0] pw, logic [15:0] refl);
		int g;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		is_first <= first;
		error_power <= pw;
		reflection <= refl;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	function automatic logic [15:0] rand_reflection();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 16'h8000;
		if (r == 1) return 16'h7FFF;
		if (r == 2) return 16'h0000;
		if (r < 12) return 16'($urandom_range(0, 4000)) ^ (($urandom_range(0, 1) != 0) ?
			16'hFFFF : 16'h0000);
		return 16'($urandom);
	endfunction

	function automatic logic [31:0] rand_power();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 32'h0;
		if (r == 1) return 32'hFFFF_FFFF;
		if (r == 2) return 32'($urandom_range(1, 255));
		return $urandom;
	endfunction

	// sender pauses until the block has drained, then lets any dropped item settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (700) @(posedge clk);
	endtask

	task automatic write_regs(logic [15:0] n, logic [20:0] ln, logic [31:0] lln);
		cfg_write <= 1'b1;
		cfg_index <= REG_SAMPLE_COUNT;
		cfg_data <= 32'(n);
		@(posedge clk);
		cfg_index <= REG_LOG_N;
		cfg_data <= 32'(ln);
		@(posedge clk);
		cfg_index <= REG_LOG_LOG_N;
		cfg_data <= lln;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic random_fits(int count);
		int len, r, stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 80) len = $urandom_range(1, 10);
			else if (r < 95) len = $urandom_range(11, 30);
			else len = $urandom_range(60, 68);
			// a few fits continue the previous one without a fresh start
			if ($urandom_range(0, 9) != 0) send_item(1'b1, rand_power(), 16'($urandom));
			repeat (len) send_item(1'b0, $urandom, rand_reflection());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_SAMPLE_COUNT;
		cfg_data = '0;
		in_valid = 1'b0;
		is_first = 1'b0;
		error_power = '0;
		reflection = '0;
		items_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: no initial power, extremes of power and reflection
		send_item(1'b0, 32'h0, 16'h1234);
		send_item(1'b0, 32'h0, 16'h7FFF);
		send_item(1'b1, 32'hFFFF_FFFF, 16'h0);
		send_item(1'b0, 32'h0, 16'h0000);
		send_item(1'b0, 32'h0, 16'h7FFF);
		send_item(1'b0, 32'h0, 16'hFFFF);
		send_item(1'b0, 32'h0, 16'h8000);
		send_item(1'b0, 32'h0, 16'h4000);
		send_item(1'b1, 32'h0, 16'hFFFF);
		send_item(1'b0, 32'hFFFF_FFFF, 16'h0000);
		send_item(1'b1, 32'h1, 16'h0);
		send_item(1'b0, 32'h0, 16'h0001);
		send_item(1'b0, 32'h0, 16'hC000);
		send_item(1'b1, 32'h0001_0000, 16'h0);
		send_item(1'b0, 32'h0, 16'hFFFF);
		send_item(1'b0, 32'h0, 16'h2000);
		random_fits(60);

		wait_drained();
		write_regs(16'd5, 21'd105476, 32'sd31000);
		random_fits(60);
		wait_drained();
		write_regs(16'd4, 21'd0, 32'h8000_0000);
		// run past the top order so the extra reflections are dropped
		send_item(1'b1, 32'h0100_0000, 16'h0);
		repeat (67) send_item(1'b0, $urandom, rand_reflection());
		random_fits(20);
		wait_drained();
		write_regs(16'd65535, 21'd1048576, 32'h7FFF_FFFF);
		random_fits(60);
		wait_drained();
		write_regs(16'd0, 21'd454277, -32'sd126992);
		random_fits(40);
		wait_drained();
		write_regs(16'd0, 21'($urandom), 32'h0);
		random_fits(30);
		wait_drained();
		write_regs(16'($urandom_range(4, 300)), 21'($urandom_range(0, 1048576)), $urandom);
		random_fits(60);
		wait_drained();
		write_regs(16'd1024, 21'd454277, 32'sd126992);
		random_fits(40);

		wait_drained();
		if (mismatch_count == 0 && results_owed == 0) begin
			$display("ar_order_selection_criteria_core: match");
		end else begin
			$display("ar_order_selection_criteria_core: mismatch");
		end
		$finish;
	end

endmodule
